>>> design/iso_pkg.sv
package iso_pkg;

  typedef enum logic [4:0] {
    PH_YEAR       = 5'd0,
    PH_DASH1      = 5'd1,
    PH_MONTH      = 5'd2,
    PH_DASH2      = 5'd3,
    PH_DAY        = 5'd4,
    PH_AFTER_DAY  = 5'd5,
    PH_HOUR       = 5'd6,
    PH_AFTER_HOUR = 5'd7,
    PH_MIN        = 5'd8,
    PH_AFTER_MIN  = 5'd9,
    PH_SEC        = 5'd10,
    PH_AFTER_SEC  = 5'd11,
    PH_FRAC_FIRST = 5'd12,
    PH_FRAC       = 5'd13,
    PH_ZONE_HH    = 5'd14,
    PH_AFTER_ZHH  = 5'd15,
    PH_ZONE_MM    = 5'd16,
    PH_DONE       = 5'd17
  } phase_e;

  typedef struct packed {
    logic        failed;
    logic        may_end;
    logic        len_ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [19:0] frac;
    logic [2:0]  frac_digits;
    logic        zone_neg;
    logic [6:0]  zone_hours;
    logic [6:0]  zone_minutes;
  } fields_t;

  typedef enum logic [6:0] {
    CS_IDLE  = 7'b0000001,
    CS_CHECK = 7'b0000010,
    CS_DAYS  = 7'b0000100,
    CS_SECS  = 7'b0001000,
    CS_ZONE  = 7'b0010000,
    CS_US    = 7'b0100000,
    CS_OUT   = 7'b1000000
  } calc_state_e;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LZ    = 8'h7a;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    begin
      case (m)
        4'd2:                       r = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
        default:                    r = 5'd31;
      endcase
      return r;
    end
  endfunction

  // Days from March 1 to the first of a March-based month.
  function automatic logic [8:0] march_doy(input logic [3:0] mp);
    logic [8:0] r;
    begin
      case (mp)
        4'd0:    r = 9'd0;
        4'd1:    r = 9'd31;
        4'd2:    r = 9'd61;
        4'd3:    r = 9'd92;
        4'd4:    r = 9'd122;
        4'd5:    r = 9'd153;
        4'd6:    r = 9'd184;
        4'd7:    r = 9'd214;
        4'd8:    r = 9'd245;
        4'd9:    r = 9'd275;
        4'd10:   r = 9'd306;
        4'd11:   r = 9'd337;
        default: r = 9'd0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> design/iso_scan.sv
module iso_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        char_i,
  input  logic              last_i,
  output iso_pkg::fields_t  fields_o
);

  iso_pkg::phase_e phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  mon_q, mon_d, day_q, day_d, hr_q, hr_d, mi_q, mi_d, se_q, se_d;
  logic [6:0]  zh_q, zh_d, zm_q, zm_d;
  logic [19:0] fr_q, fr_d;
  logic [2:0]  fd_q, fd_d;
  logic        zn_q, zn_d, fail_q, fail_d;
  logic        dig;
  logic [3:0]  dv;
  logic [3:0]  cnt_n;

  assign dig = (char_i >= iso_pkg::CH_0) && (char_i <= iso_pkg::CH_9);
  assign dv  = char_i[3:0];
  assign cnt_n = (cnt_q < 4'd10) ? cnt_q + 4'd1 : cnt_q;

  always_comb begin
    phase_d = phase_q; idx_d = idx_q; cnt_d = cnt_n;
    year_d = year_q; mon_d = mon_q; day_d = day_q; hr_d = hr_q; mi_d = mi_q;
    se_d = se_q; zh_d = zh_q; zm_d = zm_q; fr_d = fr_q; fd_d = fd_q;
    zn_d = zn_q; fail_d = fail_q;
    if (!fail_q) begin
      case (phase_q)
        iso_pkg::PH_YEAR, iso_pkg::PH_MONTH, iso_pkg::PH_DAY, iso_pkg::PH_HOUR,
        iso_pkg::PH_MIN, iso_pkg::PH_SEC, iso_pkg::PH_ZONE_HH,
        iso_pkg::PH_ZONE_MM: begin
          if (!dig) begin
            fail_d = 1'b1;
          end else begin
            idx_d = idx_q + 3'd1;
            case (phase_q)
              iso_pkg::PH_YEAR: begin
                year_d = 14'(year_q * 14'd10) + 14'(dv);
                if (idx_q == 3'd3) begin idx_d = '0; phase_d = iso_pkg::PH_DASH1; end
              end
              iso_pkg::PH_MONTH: begin
                mon_d = 7'(mon_q * 7'd10) + 7'(dv);
                if (idx_q == 3'd1) begin idx_d = '0; phase_d = iso_pkg::PH_DASH2; end
              end
              iso_pkg::PH_DAY: begin
                day_d = 7'(day_q * 7'd10) + 7'(dv);
                if (idx_q == 3'd1) begin idx_d = '0; phase_d = iso_pkg::PH_AFTER_DAY; end
              end
              iso_pkg::PH_HOUR: begin
                hr_d = 7'(hr_q * 7'd10) + 7'(dv);
                if (idx_q == 3'd1) begin idx_d = '0; phase_d = iso_pkg::PH_AFTER_HOUR; end
              end
              iso_pkg::PH_MIN: begin
                mi_d = 7'(mi_q * 7'd10) + 7'(dv);
                if (idx_q == 3'd1) begin idx_d = '0; phase_d = iso_pkg::PH_AFTER_MIN; end
              end
              iso_pkg::PH_SEC: begin
                se_d = 7'(se_q * 7'd10) + 7'(dv);
                if (idx_q == 3'd1) begin idx_d = '0; phase_d = iso_pkg::PH_AFTER_SEC; end
              end
              iso_pkg::PH_ZONE_HH: begin
                zh_d = 7'(zh_q * 7'd10) + 7'(dv);
                if (idx_q == 3'd1) begin idx_d = '0; phase_d = iso_pkg::PH_AFTER_ZHH; end
              end
              default: begin
                zm_d = 7'(zm_q * 7'd10) + 7'(dv);
                if (idx_q == 3'd1) begin idx_d = '0; phase_d = iso_pkg::PH_DONE; end
              end
            endcase
          end
        end
        iso_pkg::PH_DASH1: begin
          if (char_i == iso_pkg::CH_DASH) phase_d = iso_pkg::PH_MONTH; else fail_d = 1'b1;
        end
        iso_pkg::PH_DASH2: begin
          if (char_i == iso_pkg::CH_DASH) phase_d = iso_pkg::PH_DAY; else fail_d = 1'b1;
        end
        iso_pkg::PH_AFTER_ZHH: begin
          if (char_i == iso_pkg::CH_COLON) phase_d = iso_pkg::PH_ZONE_MM;
          else fail_d = 1'b1;
        end
        iso_pkg::PH_FRAC_FIRST: begin
          if (!dig) fail_d = 1'b1;
          else begin
            fr_d = 20'(dv); fd_d = 3'd1; phase_d = iso_pkg::PH_FRAC;
          end
        end
        iso_pkg::PH_AFTER_DAY, iso_pkg::PH_AFTER_HOUR, iso_pkg::PH_AFTER_MIN,
        iso_pkg::PH_AFTER_SEC, iso_pkg::PH_FRAC: begin
          if (phase_q == iso_pkg::PH_AFTER_DAY && char_i == iso_pkg::CH_T) begin
            phase_d = iso_pkg::PH_HOUR;
          end else if (phase_q == iso_pkg::PH_AFTER_HOUR && char_i == iso_pkg::CH_COLON) begin
            phase_d = iso_pkg::PH_MIN;
          end else if (phase_q == iso_pkg::PH_AFTER_MIN && char_i == iso_pkg::CH_COLON) begin
            phase_d = iso_pkg::PH_SEC;
          end else if (phase_q == iso_pkg::PH_AFTER_SEC && char_i == iso_pkg::CH_DOT) begin
            phase_d = iso_pkg::PH_FRAC_FIRST;
          end else if (phase_q == iso_pkg::PH_FRAC && dig) begin
            if (fd_q < 3'd6) begin
              fr_d = 20'(fr_q * 20'd10) + 20'(dv);
              fd_d = fd_q + 3'd1;
            end
          end else if (char_i == iso_pkg::CH_UZ || char_i == iso_pkg::CH_LZ) begin
            phase_d = iso_pkg::PH_DONE;
          end else if (char_i == iso_pkg::CH_PLUS || char_i == iso_pkg::CH_DASH) begin
            zn_d = (char_i == iso_pkg::CH_DASH);
            idx_d = '0;
            phase_d = iso_pkg::PH_ZONE_HH;
          end else begin
            fail_d = 1'b1;
          end
        end
        default: fail_d = 1'b1;
      endcase
    end
  end

  always_comb begin
    fields_o.failed  = fail_d;
    fields_o.may_end = (phase_d == iso_pkg::PH_AFTER_DAY) ||
                       (phase_d == iso_pkg::PH_AFTER_HOUR) ||
                       (phase_d == iso_pkg::PH_AFTER_MIN) ||
                       (phase_d == iso_pkg::PH_AFTER_SEC) ||
                       (phase_d == iso_pkg::PH_FRAC) ||
                       (phase_d == iso_pkg::PH_AFTER_ZHH) ||
                       (phase_d == iso_pkg::PH_DONE);
    fields_o.len_ok       = (cnt_d == 4'd10);
    fields_o.year         = year_d;
    fields_o.month        = mon_d;
    fields_o.day          = day_d;
    fields_o.hour         = hr_d;
    fields_o.minute       = mi_d;
    fields_o.second       = se_d;
    fields_o.frac         = fr_d;
    fields_o.frac_digits  = fd_d;
    fields_o.zone_neg     = zn_d;
    fields_o.zone_hours   = zh_d;
    fields_o.zone_minutes = zm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= iso_pkg::PH_YEAR; idx_q <= '0; cnt_q <= '0;
      year_q <= '0; mon_q <= '0; day_q <= '0; hr_q <= '0; mi_q <= '0; se_q <= '0;
      zh_q <= '0; zm_q <= '0; fr_q <= '0; fd_q <= '0; zn_q <= 1'b0; fail_q <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        phase_q <= iso_pkg::PH_YEAR; idx_q <= '0; cnt_q <= '0;
        year_q <= '0; mon_q <= '0; day_q <= '0; hr_q <= '0; mi_q <= '0; se_q <= '0;
        zh_q <= '0; zm_q <= '0; fr_q <= '0; fd_q <= '0; zn_q <= 1'b0; fail_q <= 1'b0;
      end else begin
        phase_q <= phase_d; idx_q <= idx_d; cnt_q <= cnt_d;
        year_q <= year_d; mon_q <= mon_d; day_q <= day_d; hr_q <= hr_d;
        mi_q <= mi_d; se_q <= se_d; zh_q <= zh_d; zm_q <= zm_d;
        fr_q <= fr_d; fd_q <= fd_d; zn_q <= zn_d; fail_q <= fail_d;
      end
    end
  end

endmodule

>>> design/iso_calc.sv
module iso_calc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  iso_pkg::fields_t  fields_i,
  output logic              busy_o,
  output logic              done_o,
  input  logic              ack_i,
  output logic              ok_o,
  output logic [63:0]       ts_o,
  output logic [17:0]       zone_o
);

  iso_pkg::calc_state_e st_q, st_d;
  iso_pkg::fields_t f_q;
  logic [2:0]  step_q;
  logic        ok_q;
  logic [63:0] acc_q;
  logic [31:0] us_frac_q;
  logic [16:0] mag_q;
  logic [63:0] ts_q;
  logic [21:0] days_q;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic        leap, range_ok, day_ok;
  logic [13:0] ay;
  logic [3:0]  mp;
  logic [8:0]  doy;
  logic [21:0] days;
  logic [26:0] ay_r, yr_r;
  logic [7:0]  ay_c, yr_c;
  logic        yr_hundred;

  // Division by 100 through reciprocal multiplication, exact for 14-bit years.
  assign ay_r = 27'(ay) * 27'd5243;
  assign ay_c = ay_r[26:19];
  assign yr_r = 27'(f_q.year) * 27'd5243;
  assign yr_c = yr_r[26:19];
  assign yr_hundred = (15'(f_q.year) == 15'(yr_c) * 15'd100);

  assign leap = ((f_q.year[1:0] == 2'd0) && !yr_hundred) ||
                (yr_hundred && (yr_c[1:0] == 2'd0));
  assign range_ok = !f_q.failed && f_q.len_ok && f_q.may_end &&
                    f_q.year >= 14'd1970 && f_q.year <= 14'd9999 &&
                    f_q.month >= 7'd1 && f_q.month <= 7'd12 &&
                    f_q.hour <= 7'd23 && f_q.minute <= 7'd59 && f_q.second <= 7'd59 &&
                    f_q.zone_hours <= 7'd23 && f_q.zone_minutes <= 7'd59;
  assign day_ok = f_q.day >= 7'd1 &&
                  f_q.day <= 7'(iso_pkg::month_days(f_q.month[3:0], leap));

  // Day count since 1970 with March-based years; year >= 1970 keeps it positive.
  assign ay  = f_q.year - ((f_q.month <= 7'd2) ? 14'd1 : 14'd0);
  assign mp  = (f_q.month > 7'd2) ? 4'(f_q.month - 7'd3) : 4'(f_q.month + 7'd9);
  assign doy = iso_pkg::march_doy(mp) + 9'(f_q.day) - 9'd1;
  assign days = 22'(32'(ay) * 32'd365 + 32'(ay[13:2]) - 32'(ay_c) +
                    32'(ay_c[7:2]) + 32'(doy) - 32'd719468);

  always_comb begin
    mul_a = '0; mul_b = '0;
    case (st_q)
      iso_pkg::CS_CHECK: begin mul_a = 33'(f_q.zone_hours); mul_b = 32'd3600; end
      iso_pkg::CS_DAYS:  begin mul_a = 33'(days_q); mul_b = 32'd86400; end
      iso_pkg::CS_SECS:  begin mul_a = 33'(f_q.hour); mul_b = 32'd3600; end
      iso_pkg::CS_US:    begin
        if (step_q == 3'd1) begin mul_a = 33'(us_frac_q); mul_b = 32'd10; end
        else if (step_q == 3'd0) begin mul_a = acc_q[32:0]; mul_b = 32'd1000000; end
        else begin mul_a = 33'(acc_q[63:33]); mul_b = 32'd1000000; end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      iso_pkg::CS_IDLE:  if (start_i) st_d = iso_pkg::CS_CHECK;
      iso_pkg::CS_CHECK: st_d = iso_pkg::CS_DAYS;
      iso_pkg::CS_DAYS:  st_d = iso_pkg::CS_SECS;
      iso_pkg::CS_SECS:  st_d = iso_pkg::CS_ZONE;
      iso_pkg::CS_ZONE:  st_d = iso_pkg::CS_US;
      iso_pkg::CS_US:    if (step_q == 3'd2) st_d = iso_pkg::CS_OUT;
      iso_pkg::CS_OUT:   if (ack_i) st_d = iso_pkg::CS_IDLE;
      default:           st_d = iso_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= iso_pkg::CS_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      iso_pkg::CS_IDLE: if (start_i) f_q <= fields_i;
      iso_pkg::CS_CHECK: begin
        ok_q  <= range_ok;
        mag_q <= 17'(mul_p) + 17'(f_q.zone_minutes * 13'd60);
        us_frac_q <= 32'(f_q.frac);
        days_q <= days;
        step_q <= 3'd1;
      end
      iso_pkg::CS_DAYS: begin
        ok_q  <= ok_q && day_ok;
        acc_q <= mul_p;
      end
      iso_pkg::CS_SECS: begin
        acc_q <= acc_q + mul_p + 64'(f_q.minute * 13'd60) + 64'(f_q.second);
      end
      iso_pkg::CS_ZONE: begin
        acc_q <= f_q.zone_neg ? acc_q + 64'(mag_q) : acc_q - 64'(mag_q);
        step_q <= (f_q.frac_digits >= 3'd6) ? 3'd0 : 3'd1;
      end
      iso_pkg::CS_US: begin
        if (step_q == 3'd1) begin
          if (f_q.frac_digits < 3'd6) begin
            us_frac_q <= mul_p[31:0];
            f_q.frac_digits <= f_q.frac_digits + 3'd1;
          end
          step_q <= (f_q.frac_digits >= 3'd5) ? 3'd0 : 3'd1;
        end else if (step_q == 3'd0) begin
          ts_q <= mul_p + 64'(us_frac_q);
          step_q <= 3'd2;
        end else begin
          // upper seconds bits weigh 2^33
          ts_q <= ok_q ? ts_q + {mul_p[30:0], 33'd0} : 64'd0;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (st_q != iso_pkg::CS_IDLE);
  assign done_o = (st_q == iso_pkg::CS_OUT);
  assign ok_o   = ok_q;
  assign ts_o   = ts_q;
  assign zone_o = !ok_q ? 18'd0 : (f_q.zone_neg ? 18'(-18'(mag_q)) : 18'(mag_q));

endmodule

>>> design/iso8601_timestamp_parser_unit.sv
// Sequence: a non-final character only updates the parse state; after the final
// one the shared multiplier steps through the check, day, second, zone and
// microsecond states, scaling the fraction per missing digit, before output.
// Throughput: one character per cycle while a string streams in; no input
// is taken from the final character until its result transfer completes.
// Reset: rst_ni clears all parse state and the sequencer state register; the output is idle.
module iso8601_timestamp_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_char
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata    // ok, utc_usec[64], zone_offset_sec[18], pad
);

  iso_pkg::fields_t fields;
  logic take, busy, done, ok;
  logic [63:0] ts;
  logic [17:0] zone;

  assign s_axis_tready = !busy;
  assign take = s_axis_tvalid && s_axis_tready;

  iso_scan u_scan (
    .clk_i, .rst_ni, .take_i(take), .char_i(s_axis_tdata), .last_i(s_axis_tlast),
    .fields_o(fields)
  );

  iso_calc u_calc (
    .clk_i, .rst_ni, .start_i(take && s_axis_tlast), .fields_i(fields),
    .busy_o(busy), .done_o(done), .ack_i(m_axis_tready),
    .ok_o(ok), .ts_o(ts), .zone_o(zone)
  );

  assign m_axis_tvalid = done;
  assign m_axis_tdata  = {5'd0, zone, ts, ok};

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during result");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && s_axis_tlast) |=> busy) else $error("sequencer not started");
  a_zero_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[82:1] == '0))
    else $error("nonzero payload on failure");

endmodule
